/* rtl/clhl_pkg.sv */
// ----------------------------------------------------------------------------
// clhl_pkg
// Shared types, codes and reset values of the client handshake link block.
// ----------------------------------------------------------------------------
package clhl_pkg;

    // default widths of stored node IDs and of the timeout counter
    localparam int ID_BITS_DEFAULT    = 16;
    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int FIELD_BITS = 16;
    localparam int NONCE_BITS = 64;
    localparam int CFG_INDEX_BITS = 3;

    // reset values of the configuration registers
    localparam logic [FIELD_BITS-1:0] HEARTBEAT_CODE_RESET  = 16'd0;
    localparam logic [FIELD_BITS-1:0] ACK_CODE_RESET        = 16'd1;
    localparam logic [FIELD_BITS-1:0] NACK_CODE_RESET       = 16'd2;
    localparam logic [FIELD_BITS-1:0] ANNOUNCE_CODE_RESET   = 16'd3;
    localparam logic [FIELD_BITS-1:0] DISCONNECT_CODE_RESET = 16'd4;
    localparam logic [FIELD_BITS-1:0] TIMEOUT_TICKS_RESET   = 16'd1000;
    localparam logic [FIELD_BITS-1:0] INITIAL_CLIENT_ID_RESET = 16'd1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HEARTBEAT_CODE    = 3'd0,
        CFG_ACK_CODE          = 3'd1,
        CFG_NACK_CODE         = 3'd2,
        CFG_ANNOUNCE_CODE     = 3'd3,
        CFG_DISCONNECT_CODE   = 3'd4,
        CFG_TIMEOUT_TICKS     = 3'd5,
        CFG_INITIAL_CLIENT_ID = 3'd6
    } cfg_index_t;

    // item actions
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_CONNECT = 3'd1,
        ACT_MESSAGE = 3'd2,
        ACT_SEND    = 3'd3,
        ACT_CLOSE   = 3'd4
    } action_t;

    // link state machine, one-hot
    typedef enum logic [3:0] {
        MODE_OFF    = 4'b0001,
        MODE_TRYING = 4'b0010,
        MODE_HEARD  = 4'b0100,
        MODE_LINKED = 4'b1000
    } link_mode_t;

    // externally visible link state codes
    localparam logic [1:0] LINK_CODE_OFF    = 2'd0;
    localparam logic [1:0] LINK_CODE_TRYING = 2'd1;
    localparam logic [1:0] LINK_CODE_HEARD  = 2'd2;
    localparam logic [1:0] LINK_CODE_LINKED = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_NOT_CONNECTED = 2'd1,
        STATUS_IGNORED       = 2'd2
    } status_t;

    // command codes and timeout setting
    typedef struct packed {
        logic [FIELD_BITS-1:0] heartbeat_code;
        logic [FIELD_BITS-1:0] ack_code;
        logic [FIELD_BITS-1:0] nack_code;
        logic [FIELD_BITS-1:0] announce_code;
        logic [FIELD_BITS-1:0] disconnect_code;
        logic [FIELD_BITS-1:0] timeout_ticks;
    } cfg_t;

    // one input transaction
    typedef struct packed {
        logic [2:0]            action;
        logic [FIELD_BITS-1:0] src_node;
        logic [FIELD_BITS-1:0] dest_topic;
        logic [FIELD_BITS-1:0] cmd_code;
        logic                  is_control;
        logic                  has_data_list;
        logic                  has_nonce;
        logic [NONCE_BITS-1:0] msg_nonce;
        logic [NONCE_BITS-1:0] fresh_nonce;
        logic [FIELD_BITS-1:0] fresh_id;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]            link_state;
        logic                  send_valid;
        logic                  send_is_control;
        logic [FIELD_BITS-1:0] send_topic;
        logic [FIELD_BITS-1:0] send_sender;
        logic [FIELD_BITS-1:0] send_command;
        logic [NONCE_BITS-1:0] send_nonce;
        logic                  deliver_data;
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] client_id;
    } result_t;

    // one-hot link mode to its external code
    function automatic logic [1:0] mode_code(input link_mode_t mode);
        logic [1:0] code;
        case (mode)
            MODE_TRYING: code = LINK_CODE_TRYING;
            MODE_HEARD:  code = LINK_CODE_HEARD;
            MODE_LINKED: code = LINK_CODE_LINKED;
            default:     code = LINK_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

/* rtl/clhl_step.sv */
// ----------------------------------------------------------------------------
// clhl_step
// Next link state and result of one transaction, from the current state.
// ----------------------------------------------------------------------------
module clhl_step #(
    parameter int ID_BITS    = clhl_pkg::ID_BITS_DEFAULT,
    parameter int TIMER_BITS = clhl_pkg::TIMER_BITS_DEFAULT
) (
    input  clhl_pkg::item_t                   item,
    input  clhl_pkg::cfg_t                    cfg,
    input  clhl_pkg::link_mode_t              mode_cur,
    input  logic [ID_BITS-1:0]                own_id_cur,
    input  logic [ID_BITS-1:0]                server_cur,
    input  logic [clhl_pkg::NONCE_BITS-1:0]   nonce_cur,
    input  logic [TIMER_BITS-1:0]             ticks_cur,
    output clhl_pkg::link_mode_t              mode_new,
    output logic [ID_BITS-1:0]                own_id_new,
    output logic [ID_BITS-1:0]                server_new,
    output logic [clhl_pkg::NONCE_BITS-1:0]   nonce_new,
    output logic [TIMER_BITS-1:0]             ticks_new,
    output clhl_pkg::result_t                 result
);

    logic [ID_BITS-1:0]    sender;
    logic [ID_BITS-1:0]    topic;
    logic [ID_BITS-1:0]    fresh_id;
    logic [TIMER_BITS-1:0] timeout_load;
    logic                  is_ack;
    logic                  is_nack;
    logic                  handshake_ok;

    // ids held at ID_BITS, timer load cut to TIMER_BITS
    assign sender       = ID_BITS'(item.src_node);
    assign topic        = ID_BITS'(item.dest_topic);
    assign fresh_id     = ID_BITS'(item.fresh_id);
    assign timeout_load = TIMER_BITS'(cfg.timeout_ticks);

    // ack or nack that answers our announce
    assign is_ack       = (item.cmd_code == cfg.ack_code);
    assign is_nack      = (item.cmd_code == cfg.nack_code);
    assign handshake_ok = (sender == server_cur) && (is_ack || is_nack)
                          && item.has_nonce && (item.msg_nonce == nonce_cur);

    // transaction handling
    always_comb
    begin
        clhl_pkg::status_t stat;
        stat       = clhl_pkg::STATUS_OK;
        mode_new   = mode_cur;
        own_id_new = own_id_cur;
        server_new = server_cur;
        nonce_new  = nonce_cur;
        ticks_new  = ticks_cur;
        result     = '0;

        case (clhl_pkg::action_t'(item.action))
            clhl_pkg::ACT_TICK:
            begin
                if (mode_cur == clhl_pkg::MODE_LINKED)
                begin
                    if (ticks_cur <= TIMER_BITS'(1))
                    begin
                        ticks_new = '0;
                        mode_new  = clhl_pkg::MODE_OFF;
                    end
                    else
                    begin
                        ticks_new = ticks_cur - TIMER_BITS'(1);
                    end
                end
            end
            clhl_pkg::ACT_CONNECT:
            begin
                if (mode_cur == clhl_pkg::MODE_OFF)
                    mode_new = clhl_pkg::MODE_TRYING;
            end
            clhl_pkg::ACT_MESSAGE:
            begin
                if (sender[0] || !item.has_data_list)
                begin
                    stat = clhl_pkg::STATUS_IGNORED;
                end
                else
                begin
                    // any accepted traffic from the connected server keeps the link alive
                    if (mode_cur == clhl_pkg::MODE_LINKED && sender == server_cur)
                        ticks_new = timeout_load;
                    if (!item.is_control)
                    begin
                        if (topic == own_id_cur)
                            result.deliver_data = 1'b1;
                        else
                            stat = clhl_pkg::STATUS_IGNORED;
                    end
                    else
                    begin
                        stat = clhl_pkg::STATUS_IGNORED;
                        if (mode_cur == clhl_pkg::MODE_TRYING)
                        begin
                            // heartbeat: remember server and announce
                            if (item.cmd_code == cfg.heartbeat_code)
                            begin
                                server_new             = sender;
                                mode_new               = clhl_pkg::MODE_HEARD;
                                nonce_new              = item.fresh_nonce;
                                result.send_valid      = 1'b1;
                                result.send_is_control = 1'b1;
                                result.send_topic      = clhl_pkg::FIELD_BITS'(sender);
                                result.send_sender     = clhl_pkg::FIELD_BITS'(own_id_cur);
                                result.send_command    = cfg.announce_code;
                                result.send_nonce      = item.fresh_nonce;
                                stat                   = clhl_pkg::STATUS_OK;
                            end
                        end
                        else if (mode_cur == clhl_pkg::MODE_HEARD)
                        begin
                            if (handshake_ok)
                            begin
                                // ack takes priority when both codes match
                                if (is_ack)
                                begin
                                    mode_new  = clhl_pkg::MODE_LINKED;
                                    ticks_new = timeout_load;
                                end
                                else
                                begin
                                    mode_new   = clhl_pkg::MODE_OFF;
                                    own_id_new = fresh_id;
                                end
                                stat = clhl_pkg::STATUS_OK;
                            end
                        end
                    end
                end
            end
            clhl_pkg::ACT_SEND:
            begin
                if (mode_cur == clhl_pkg::MODE_LINKED)
                begin
                    result.send_valid   = 1'b1;
                    result.send_topic   = clhl_pkg::FIELD_BITS'(own_id_cur);
                    result.send_sender  = clhl_pkg::FIELD_BITS'(own_id_cur);
                    result.send_command = item.cmd_code;
                end
                else
                begin
                    stat = clhl_pkg::STATUS_NOT_CONNECTED;
                end
            end
            clhl_pkg::ACT_CLOSE:
            begin
                if (mode_cur == clhl_pkg::MODE_LINKED)
                begin
                    result.send_valid      = 1'b1;
                    result.send_is_control = 1'b1;
                    result.send_topic      = clhl_pkg::FIELD_BITS'(server_cur);
                    result.send_sender     = clhl_pkg::FIELD_BITS'(own_id_cur);
                    result.send_command    = cfg.disconnect_code;
                end
                mode_new  = clhl_pkg::MODE_OFF;
                ticks_new = '0;
            end
            default:
            begin
                stat = clhl_pkg::STATUS_IGNORED;
            end
        endcase

        result.link_state = clhl_pkg::mode_code(mode_new);
        result.status     = stat;
        result.client_id  = clhl_pkg::FIELD_BITS'(own_id_new);
    end

endmodule

/* rtl/client_handshake_link_fsm.sv */
// ----------------------------------------------------------------------------
// client_handshake_link_fsm
// Client side of a heartbeat, announce and acknowledge link handshake.
// ----------------------------------------------------------------------------
// Input register, then result register; throughput one transaction per cycle
// while the result register can drain (out_ready), with the state updated
// between the two registers.
// Reset (rst_n low, asynchronous): link disconnected, own ID 1, server ID,
// nonce and timer zero, command codes and timeout back to their defaults.
// ----------------------------------------------------------------------------
module client_handshake_link_fsm #(
    parameter int ID_BITS    = clhl_pkg::ID_BITS_DEFAULT,
    parameter int TIMER_BITS = clhl_pkg::TIMER_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] src_node,
    input  logic [15:0] dest_topic,
    input  logic [15:0] cmd_code,
    input  logic        is_control,
    input  logic        has_data_list,
    input  logic        has_nonce,
    input  logic [63:0] msg_nonce,
    input  logic [63:0] fresh_nonce,
    input  logic [15:0] fresh_id,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  link_state,
    output logic        send_valid,
    output logic        send_is_control,
    output logic [15:0] send_topic,
    output logic [15:0] send_sender,
    output logic [15:0] send_command,
    output logic [63:0] send_nonce,
    output logic        deliver_data,
    output logic [1:0]  status,
    output logic [15:0] client_id
);

    clhl_pkg::cfg_t                    cfg_reg;
    clhl_pkg::item_t                   item_reg;
    logic                              item_full_reg;
    clhl_pkg::result_t                 result_reg;
    logic                              out_valid_reg;

    clhl_pkg::link_mode_t              mode_reg;
    clhl_pkg::link_mode_t              mode_next;
    logic [ID_BITS-1:0]                own_id_reg;
    logic [ID_BITS-1:0]                own_id_next;
    logic [ID_BITS-1:0]                server_reg;
    logic [ID_BITS-1:0]                server_next;
    logic [clhl_pkg::NONCE_BITS-1:0]   nonce_reg;
    logic [clhl_pkg::NONCE_BITS-1:0]   nonce_next;
    logic [TIMER_BITS-1:0]             ticks_reg;
    logic [TIMER_BITS-1:0]             ticks_next;
    clhl_pkg::result_t                 result_next;

    logic                              advance;
    logic                              in_take;

    // pipeline flow: item moves to the result register when that slot frees up
    assign advance   = item_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_full_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration registers; the initial client ID only matters at reset,
    // which also restores it, so its writes are taken and dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_code  <= clhl_pkg::HEARTBEAT_CODE_RESET;
            cfg_reg.ack_code        <= clhl_pkg::ACK_CODE_RESET;
            cfg_reg.nack_code       <= clhl_pkg::NACK_CODE_RESET;
            cfg_reg.announce_code   <= clhl_pkg::ANNOUNCE_CODE_RESET;
            cfg_reg.disconnect_code <= clhl_pkg::DISCONNECT_CODE_RESET;
            cfg_reg.timeout_ticks   <= clhl_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            case (clhl_pkg::cfg_index_t'(cfg_index))
                clhl_pkg::CFG_HEARTBEAT_CODE:  cfg_reg.heartbeat_code  <= cfg_data;
                clhl_pkg::CFG_ACK_CODE:        cfg_reg.ack_code        <= cfg_data;
                clhl_pkg::CFG_NACK_CODE:       cfg_reg.nack_code       <= cfg_data;
                clhl_pkg::CFG_ANNOUNCE_CODE:   cfg_reg.announce_code   <= cfg_data;
                clhl_pkg::CFG_DISCONNECT_CODE: cfg_reg.disconnect_code <= cfg_data;
                clhl_pkg::CFG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action        <= action;
            item_reg.src_node      <= src_node;
            item_reg.dest_topic    <= dest_topic;
            item_reg.cmd_code      <= cmd_code;
            item_reg.is_control    <= is_control;
            item_reg.has_data_list <= has_data_list;
            item_reg.has_nonce     <= has_nonce;
            item_reg.msg_nonce     <= msg_nonce;
            item_reg.fresh_nonce   <= fresh_nonce;
            item_reg.fresh_id      <= fresh_id;
        end
    end

    // transaction logic
    clhl_step #(
        .ID_BITS    (ID_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .mode_cur   (mode_reg),
        .own_id_cur (own_id_reg),
        .server_cur (server_reg),
        .nonce_cur  (nonce_reg),
        .ticks_cur  (ticks_reg),
        .mode_new   (mode_next),
        .own_id_new (own_id_next),
        .server_new (server_next),
        .nonce_new  (nonce_next),
        .ticks_new  (ticks_next),
        .result     (result_next)
    );

    // link state and handshake valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= clhl_pkg::MODE_OFF;
            own_id_reg    <= ID_BITS'(clhl_pkg::INITIAL_CLIENT_ID_RESET);
            server_reg    <= '0;
            nonce_reg     <= '0;
            ticks_reg     <= '0;
        end
        else
        begin
            if (in_take)
                item_full_reg <= 1'b1;
            else if (advance)
                item_full_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                mode_reg   <= mode_next;
                own_id_reg <= own_id_next;
                server_reg <= server_next;
                nonce_reg  <= nonce_next;
                ticks_reg  <= ticks_next;
            end
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign link_state      = result_reg.link_state;
    assign send_valid      = result_reg.send_valid;
    assign send_is_control = result_reg.send_is_control;
    assign send_topic      = result_reg.send_topic;
    assign send_sender     = result_reg.send_sender;
    assign send_command    = result_reg.send_command;
    assign send_nonce      = result_reg.send_nonce;
    assign deliver_data    = result_reg.deliver_data;
    assign status          = result_reg.status;
    assign client_id       = result_reg.client_id;

endmodule
